@@ src/scss_pkg.sv @@
// Shared constants, types and helper functions of the smart-case substring search.
package scss_pkg;

    localparam int PATTERN_MAX = 16;
    localparam int IDX_W       = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
    localparam int LEN_W       = $clog2(PATTERN_MAX + 1);
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_IDX_W   = 2;
    localparam int LEN_REG_W   = 5;
    localparam int COLS_W      = 10;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_COLS  = 2'd3;

    localparam logic [LEN_REG_W-1:0] LEN_RESET  = 5'd1;
    localparam logic [COLS_W-1:0]    COLS_RESET = 10'd80;

    typedef logic [PATTERN_MAX-1:0][7:0] window_t;

    // Configuration as seen by the datapath.
    typedef struct packed {
        window_t           pattern;
        logic [IDX_W-1:0]  len_m1;
        logic              sensitive;
        logic [COLS_W-1:0] cols;
    } cfg_t;

    // Stage-one contents: state after the newest accepted byte plus its flags.
    typedef struct packed {
        window_t     window;
        logic [LEN_W-1:0] seen;
        logic [31:0] offset;
        logic [31:0] line_start;
        logic [31:0] line;
        logic [31:0] line_diff;
        logic        first;
        logic        last;
    } trk_t;

    function automatic logic is_upper(input logic [7:0] c);
        return c inside {[8'h41:8'h5A]};
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return c inside {[8'h61:8'h7A]};
    endfunction

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        return is_upper(c) ? (c + 8'd32) : c;
    endfunction

endpackage

@@ src/scss_cfg.sv @@
// Configuration registers and the values derived from them.
module scss_cfg
    import scss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [63:0]          pat_low_reg;
    logic [63:0]          pat_high_reg;
    logic [LEN_REG_W-1:0] len_reg;
    logic [COLS_W-1:0]    cols_reg;

    logic [127:0]         pat_all;
    window_t              pat;
    logic [LEN_REG_W-1:0] len_clamped;
    logic [IDX_W-1:0]     len_m1;
    logic                 any_upper;
    logic                 any_lower;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_high_reg <= '0;
            len_reg      <= LEN_RESET;
            cols_reg     <= COLS_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_PATTERN_LOW:  pat_low_reg  <= cfg_data;
                REG_PATTERN_HIGH: pat_high_reg <= cfg_data;
                REG_PATTERN_LEN:  len_reg      <= cfg_data[LEN_REG_W-1:0];
                REG_SCREEN_COLS:  cols_reg     <= cfg_data[COLS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        pat_all = {pat_high_reg, pat_low_reg};
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            pat[i] = pat_all[8*i +: 8];
        end

        // A length of zero counts as one; anything above the window depth is clamped.
        if (len_reg == '0)
            len_clamped = LEN_REG_W'(1);
        else if (len_reg > LEN_REG_W'(PATTERN_MAX))
            len_clamped = LEN_REG_W'(PATTERN_MAX);
        else
            len_clamped = len_reg;
        len_m1 = IDX_W'(len_clamped - LEN_REG_W'(1));

        any_upper = 1'b0;
        any_lower = 1'b0;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if (IDX_W'(i) <= len_m1)
            begin
                any_upper = any_upper | is_upper(pat[i]);
                any_lower = any_lower | is_lower(pat[i]);
            end
        end

        cfg.pattern   = pat;
        cfg.len_m1    = len_m1;
        cfg.sensitive = any_upper & any_lower;
        cfg.cols      = cols_reg;
    end

endmodule

@@ src/scss_track.sv @@
// Input stage: byte window, offset, line start and line count per accepted beat.
module scss_track
    import scss_pkg::*;
(
    input  logic        clk,
    input  logic        load,
    input  logic [7:0]  data_byte,
    input  logic        first_of_search,
    input  logic        last_of_file,
    input  logic [31:0] start_offset,
    input  logic [31:0] start_line_offset,
    input  logic [31:0] start_line_number,
    output trk_t        trk
);

    trk_t        trk_reg;
    trk_t        trk_next;
    logic [31:0] off;
    logic [31:0] base_ls;
    logic [31:0] base_line;
    logic        is_nl;

    always_comb
    begin
        off       = first_of_search ? start_offset      : (trk_reg.offset + 32'd1);
        base_ls   = first_of_search ? start_line_offset : trk_reg.line_start;
        base_line = first_of_search ? start_line_number : trk_reg.line;
        is_nl     = (data_byte == NEWLINE_BYTE);

        trk_next = trk_reg;
        trk_next.first  = first_of_search;
        trk_next.last   = last_of_file;
        trk_next.offset = off;

        if (first_of_search)
        begin
            trk_next.window = '0;
            trk_next.seen   = LEN_W'(1);
        end
        else
        begin
            for (int i = PATTERN_MAX - 1; i > 0; i--)
            begin
                trk_next.window[i] = trk_reg.window[i-1];
            end
            if (trk_reg.seen < LEN_W'(PATTERN_MAX))
                trk_next.seen = trk_reg.seen + LEN_W'(1);
        end
        trk_next.window[0] = data_byte;

        // A line number of zero means unknown and is never advanced.
        if (is_nl)
        begin
            trk_next.line_start = off + 32'd1;
            trk_next.line       = (base_line != 32'd0) ? (base_line + 32'd1) : base_line;
            trk_next.line_diff  = 32'hFFFF_FFFF;
        end
        else
        begin
            trk_next.line_start = base_ls;
            trk_next.line       = base_line;
            trk_next.line_diff  = off - base_ls;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            trk_reg <= trk_next;
    end

    assign trk = trk_reg;

endmodule

@@ src/scss_match.sv @@
// Window compare and result fields for the byte held in the input stage.
module scss_match
    import scss_pkg::*;
(
    input  cfg_t        cfg,
    input  trk_t        trk,
    output logic        hit,
    output logic [31:0] match_off,
    output logic [31:0] shift
);

    logic [IDX_W-1:0] idx;
    logic [7:0]       p;
    logic [7:0]       d;
    logic             all_eq;
    logic [31:0]      col;
    logic [COLS_W-1:0] thr;
    logic             at_edge;
    logic [31:0]      sdiff;

    always_comb
    begin
        all_eq = 1'b1;
        idx    = '0;
        p      = '0;
        d      = '0;
        // Pattern byte i lines up with the byte that arrived len_m1 - i beats ago.
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            idx = cfg.len_m1 - IDX_W'(i);
            p   = cfg.pattern[i];
            d   = trk.window[idx];
            if (!cfg.sensitive)
            begin
                p = fold_case(p);
                d = fold_case(d);
            end
            if ((IDX_W'(i) <= cfg.len_m1) && (p != d))
                all_eq = 1'b0;
        end
        hit = all_eq && (trk.seen > LEN_W'(cfg.len_m1));

        match_off = trk.offset - 32'(cfg.len_m1);

        // Column of the match; its top bit set means the match spans a newline.
        col     = trk.line_diff - 32'(cfg.len_m1);
        thr     = cfg.cols - COLS_W'(2);
        at_edge = (cfg.cols < COLS_W'(2)) || (col[30:0] >= 31'(thr));
        sdiff   = {1'b0, col[30:0]} - 32'(cfg.cols >> 1);
        if (col[31] || !at_edge || sdiff[31])
            shift = 32'd0;
        else
            shift = sdiff;
    end

endmodule

@@ src/smart_case_substring_search.sv @@
// Top level of the streaming smart-case substring search.
//
//   channel  | handshake           | beat contents
//   ---------+---------------------+------------------------------------------------
//   input    | in_valid / in_stall | data_byte, first_of_search, last_of_file, start_*
//   output   | out_valid/out_stall | found, match_offset, line_start_offset, ...
//   config   | cfg_write_en        | cfg_index, cfg_data
//
// One byte is taken per cycle while in_stall is low. The byte that causes a result passes
// first through the input stage register and then through the result register.
// Reset clears the pipeline valid bits and leaves the search idle until a first byte.
// The input is stalled only when a result is due while the result register is still held.
module smart_case_substring_search
    import scss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            data_byte,
    input  logic                  first_of_search,
    input  logic                  last_of_file,
    input  logic [31:0]           start_offset,
    input  logic [31:0]           start_line_offset,
    input  logic [31:0]           start_line_number,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  found,
    output logic [31:0]           match_offset,
    output logic [31:0]           line_start_offset,
    output logic [31:0]           line_number,
    output logic [31:0]           horizontal_shift
);

    cfg_t        cfg;
    trk_t        trk;
    logic        hit;
    logic [31:0] m_off;
    logic [31:0] m_shift;

    logic        s1_valid_reg;
    logic        done_reg;
    logic        out_valid_reg;
    logic        found_reg;
    logic [31:0] match_offset_reg;
    logic [31:0] line_start_reg;
    logic [31:0] line_number_reg;
    logic [31:0] shift_reg;

    logic        in_acc;
    logic        active;
    logic        emit;
    logic        out_free;
    logic        advance;

    scss_cfg u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cfg          (cfg)
    );

    scss_track u_track (
        .clk               (clk),
        .load              (in_acc),
        .data_byte         (data_byte),
        .first_of_search   (first_of_search),
        .last_of_file      (last_of_file),
        .start_offset      (start_offset),
        .start_line_offset (start_line_offset),
        .start_line_number (start_line_number),
        .trk               (trk)
    );

    scss_match u_match (
        .cfg       (cfg),
        .trk       (trk),
        .hit       (hit),
        .match_off (m_off),
        .shift     (m_shift)
    );

    // Bytes after a result are dropped here until the next first byte of a search.
    assign active   = s1_valid_reg && (trk.first || !done_reg);
    assign emit     = active && (hit || trk.last);
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = !emit || out_free;
    assign in_stall = !advance;
    assign in_acc   = in_valid && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            done_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
                s1_valid_reg <= in_valid;
            if (active && advance)
                done_reg <= emit;
            if (out_free)
                out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit && out_free)
        begin
            found_reg        <= hit;
            match_offset_reg <= hit ? m_off      : 32'd0;
            line_start_reg   <= hit ? trk.line_start : 32'd0;
            line_number_reg  <= hit ? trk.line   : 32'd0;
            shift_reg        <= hit ? m_shift    : 32'd0;
        end
    end

    assign out_valid         = out_valid_reg;
    assign found             = found_reg;
    assign match_offset      = match_offset_reg;
    assign line_start_offset = line_start_reg;
    assign line_number       = line_number_reg;
    assign horizontal_shift  = shift_reg;

endmodule

@@ tb/smart_case_substring_search_test.sv @@
// Self-checking testbench for the streaming smart-case substring search.
`timescale 1ns / 1ps

module smart_case_substring_search_test;
    import scss_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_BYTES  = 1800;

    typedef struct packed {
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic [31:0] offs;
        logic [31:0] line_offs;
        logic [31:0] line_num;
    } byte_beat_t;

    typedef struct packed {
        logic        found;
        logic [31:0] offs;
        logic [31:0] line_start;
        logic [31:0] line;
        logic [31:0] shift;
    } hit_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_PATTERN_LOW;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            data_byte = '0;
    logic                  first_of_search = 1'b0;
    logic                  last_of_file = 1'b0;
    logic [31:0]           start_offset = '0;
    logic [31:0]           start_line_offset = '0;
    logic [31:0]           start_line_number = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic                  found;
    logic [31:0]           match_offset;
    logic [31:0]           line_start_offset;
    logic [31:0]           line_number;
    logic [31:0]           horizontal_shift;

    // Predictor copy of the configuration registers.
    logic [63:0] pat_lo = '0;
    logic [63:0] pat_hi = '0;
    logic [4:0]  pat_len = LEN_RESET;
    logic [9:0]  screen_cols = COLS_RESET;

    // Predictor copy of the search state.
    logic [7:0]  win [PATTERN_MAX];
    int          win_fill = 0;
    logic [31:0] next_offs = '0;
    logic [31:0] line_start = '0;
    logic [31:0] line_count = '0;
    bit          searching = 1'b0;

    hit_t expected_hits[$];
    int   errors = 0;
    int   live_bytes = 0;
    int   quiet_cycles = 0;
    bit   in_hurry = 1'b0;
    bit   out_hurry = 1'b0;

    smart_case_substring_search uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write_en      (cfg_write_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .data_byte         (data_byte),
        .first_of_search   (first_of_search),
        .last_of_file      (last_of_file),
        .start_offset      (start_offset),
        .start_line_offset (start_line_offset),
        .start_line_number (start_line_number),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .found             (found),
        .match_offset      (match_offset),
        .line_start_offset (line_start_offset),
        .line_number       (line_number),
        .horizontal_shift  (horizontal_shift)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
    endfunction

    function automatic logic [7:0] flip_case(input logic [7:0] c);
        if (c >= 8'h41 && c <= 8'h5A)
            return c + 8'd32;
        if (c >= 8'h61 && c <= 8'h7A)
            return c - 8'd32;
        return c;
    endfunction

    function automatic int eff_length();
        if (pat_len == 0)
            return 1;
        return (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
    endfunction

    function automatic logic [7:0] pat_at(input int i);
        return (i < 8) ? pat_lo[8*i +: 8] : pat_hi[8*(i-8) +: 8];
    endfunction

    function automatic bit window_hit();
        int n;
        bit has_upper;
        bit has_lower;
        logic [7:0] p;
        logic [7:0] d;
        n = eff_length();
        has_upper = 1'b0;
        has_lower = 1'b0;
        if (win_fill < n)
            return 1'b0;
        for (int i = 0; i < n; i++)
        begin
            p = pat_at(i);
            if (p >= 8'h41 && p <= 8'h5A)
                has_upper = 1'b1;
            if (p >= 8'h61 && p <= 8'h7A)
                has_lower = 1'b1;
        end
        for (int i = 0; i < n; i++)
        begin
            p = pat_at(i);
            d = win[n-1-i];
            // A pattern with both cases is compared exactly.
            if (!(has_upper && has_lower))
            begin
                p = to_lower(p);
                d = to_lower(d);
            end
            if (p != d)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic logic [31:0] shift_for_col(input logic [31:0] m, input logic [31:0] ls);
        logic [31:0] d;
        longint col;
        longint thr;
        longint s;
        int cols_i;
        d = m - ls;
        // A negative column means the match runs across a newline.
        if (d[31])
            return '0;
        cols_i = screen_cols;
        col = d;
        thr = cols_i - 2;
        if (col < thr)
            return '0;
        s = col - (cols_i / 2);
        if (s < 0)
            s = 0;
        return s[31:0];
    endfunction

    function automatic bit track_byte(input byte_beat_t b, output hit_t h);
        logic [31:0] off;
        h = '0;
        if (b.first)
        begin
            foreach (win[i])
                win[i] = '0;
            win_fill = 0;
            next_offs = b.offs;
            line_start = b.line_offs;
            line_count = b.line_num;
            searching = 1'b1;
        end
        if (!searching)
            return 1'b0;
        off = next_offs;
        next_offs = off + 1;
        for (int i = PATTERN_MAX - 1; i > 0; i--)
            win[i] = win[i-1];
        win[0] = b.data;
        if (win_fill < PATTERN_MAX)
            win_fill++;
        if (b.data == NEWLINE_BYTE)
        begin
            // An unknown line number stays unknown, also after a wrap to zero.
            if (line_count != 0)
                line_count++;
            line_start = off + 1;
        end
        if (window_hit())
        begin
            h.found = 1'b1;
            h.offs = off - (eff_length() - 1);
            h.line_start = line_start;
            h.line = line_count;
            h.shift = shift_for_col(h.offs, line_start);
            searching = 1'b0;
            return 1'b1;
        end
        if (b.last)
        begin
            searching = 1'b0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic byte_beat_t beat(input logic [7:0] data, input logic first,
                                        input logic last, input logic [31:0] offs,
                                        input logic [31:0] line_offs,
                                        input logic [31:0] line_num);
        byte_beat_t b;
        b.data = data;
        b.first = first;
        b.last = last;
        b.offs = offs;
        b.line_offs = line_offs;
        b.line_num = line_num;
        return b;
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'h61;
            1: return 8'h62;
            2: return 8'h41;
            3: return 8'h42;
            4: return NEWLINE_BYTE;
            5: return 8'h00;
            6: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic note_failure(input string msg);
        errors++;
        if (errors <= 10)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic send_byte(input byte_beat_t b);
        int gap;
        hit_t h;
        gap = in_hurry ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        data_byte <= b.data;
        first_of_search <= b.first;
        last_of_file <= b.last;
        start_offset <= b.offs;
        start_line_offset <= b.line_offs;
        start_line_number <= b.line_num;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        live_bytes++;
        if (track_byte(b, h))
            expected_hits.push_back(h);
    endtask

    // Lets every result come out, then gives the pipeline time to empty.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic program_search(input logic [63:0] lo, input logic [63:0] hi,
                                  input logic [4:0] len, input logic [9:0] cols);
        logic [63:0] junk;
        junk = {$urandom, $urandom};
        cfg_write_en <= 1'b1;
        cfg_index <= REG_PATTERN_LOW;
        cfg_data <= lo;
        pat_lo = lo;
        @(posedge clk);
        cfg_index <= REG_PATTERN_HIGH;
        cfg_data <= hi;
        pat_hi = hi;
        @(posedge clk);
        cfg_index <= REG_PATTERN_LEN;
        cfg_data <= {junk[63:5], len};
        pat_len = len;
        @(posedge clk);
        cfg_index <= REG_SCREEN_COLS;
        cfg_data <= {junk[63:10], cols};
        screen_cols = cols;
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Default pattern is a single zero byte; idle bytes are ignored before and after it.
    task automatic test_reset_state();
        send_byte(beat(8'h00, 1'b0, 1'b1, $urandom, $urandom, $urandom));
        send_byte(beat(8'hFF, 1'b1, 1'b0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF));
        send_byte(beat(NEWLINE_BYTE, 1'b0, 1'b0, $urandom, $urandom, $urandom));
        send_byte(beat(8'h00, 1'b0, 1'b0, $urandom, $urandom, $urandom));
        send_byte(beat(8'h00, 1'b0, 1'b1, $urandom, $urandom, $urandom));
    endtask

    task automatic test_exact_case();
        wait_drained();
        program_search({$urandom, 16'h0, 8'h62, 8'h41}, {$urandom, $urandom}, 5'd2, 10'd2);
        send_byte(beat(8'h61, 1'b1, 1'b0, 32'd100, 32'd86, 32'd5));
        send_byte(beat(8'h62, 1'b0, 1'b0, $urandom, $urandom, $urandom));
        send_byte(beat(8'h41, 1'b0, 1'b0, $urandom, $urandom, $urandom));
        send_byte(beat(8'h62, 1'b0, 1'b0, $urandom, $urandom, $urandom));
    endtask

    task automatic test_folded_case();
        wait_drained();
        program_search({$urandom, 16'h0, 8'h62, 8'h61}, {$urandom, $urandom}, 5'd2, 10'd0);
        send_byte(beat(8'h78, 1'b1, 1'b1, $urandom, $urandom, $urandom));
        send_byte(beat(8'h41, 1'b1, 1'b0, 32'd7, 32'd0, 32'd0));
        send_byte(beat(8'h42, 1'b0, 1'b1, $urandom, $urandom, $urandom));
    endtask

    // Oversized length clamps to a full window; the match lands on the last byte.
    task automatic test_full_window();
        wait_drained();
        program_search(64'h4A0A00FF5A415121, 64'h5AFF0041310A807E, 5'd31, 10'd1023);
        for (int i = 0; i < PATTERN_MAX; i++)
            send_byte(beat(to_lower(pat_at(i)), i == 0, i == PATTERN_MAX - 1,
                           32'h7FFF_FFFA, 32'h8000_0000, 32'd1));
    endtask

    task automatic pick_random_setup();
        logic [7:0] pb;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [4:0] len;
        logic [9:0] cols;
        int mode;
        mode = $urandom_range(0, 2);
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            pb = pick_byte();
            if (mode != 0)
            begin
                pb = to_lower(pb);
                if (mode == 2)
                    pb = flip_case(pb);
            end
            if (i < 8)
                lo[8*i +: 8] = pb;
            else
                hi[8*(i-8) +: 8] = pb;
        end
        case ($urandom_range(0, 9))
            0: len = 5'd0;
            1: len = 5'($urandom_range(17, 31));
            2: len = 5'd16;
            3: len = 5'($urandom_range(5, 15));
            default: len = 5'($urandom_range(1, 4));
        endcase
        case ($urandom_range(0, 5))
            0: cols = 10'($urandom_range(0, 1));
            1: cols = 10'd1023;
            2: cols = 10'($urandom_range(2, 1023));
            default: cols = 10'($urandom_range(2, 40));
        endcase
        in_hurry = ($urandom_range(0, 3) == 0);
        out_hurry = ($urandom_range(0, 3) == 0);
        program_search(lo, hi, len, cols);
    endtask

    task automatic run_search();
        logic [7:0] stream[$];
        int body;
        int at;
        bit ragged;
        bit with_last;
        logic [31:0] offs;
        logic [31:0] loffs;
        logic [31:0] lnum;
        byte_beat_t b;
        body = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 20);
        repeat (body) stream.push_back(pick_byte());
        if ($urandom_range(0, 3) != 0)
        begin
            ragged = $urandom_range(0, 1);
            at = $urandom_range(0, body);
            for (int i = eff_length() - 1; i >= 0; i--)
                stream.insert(at, (ragged && $urandom_range(0, 3) == 0) ?
                                  flip_case(pat_at(i)) : pat_at(i));
        end
        if (stream.size() == 0)
            stream.push_back(pick_byte());
        case ($urandom_range(0, 3))
            0: offs = $urandom;
            1: offs = 32'hFFFF_FFFF - $urandom_range(0, 40);
            2: offs = '0;
            default: offs = $urandom_range(0, 5000);
        endcase
        loffs = ($urandom_range(0, 3) == 0) ? $urandom : offs - $urandom_range(0, 1100);
        case ($urandom_range(0, 3))
            0: lnum = '0;
            1: lnum = 32'hFFFF_FFFF - $urandom_range(0, 2);
            2: lnum = $urandom;
            default: lnum = $urandom_range(1, 1000);
        endcase
        with_last = ($urandom_range(0, 4) != 0);
        foreach (stream[i])
        begin
            b = beat(stream[i], (i == 0) || ($urandom_range(0, 99) == 0),
                     with_last && (i == stream.size() - 1), $urandom, $urandom, $urandom);
            if (i == 0)
            begin
                b.offs = offs;
                b.line_offs = loffs;
                b.line_num = lnum;
            end
            send_byte(b);
        end
        repeat ($urandom_range(0, 2))
            send_byte(beat(pick_byte(), 1'b0, 1'($urandom_range(0, 1)),
                           $urandom, $urandom, $urandom));
    endtask

    task automatic test_random_searches();
        int target;
        target = live_bytes + RANDOM_BYTES;
        while (live_bytes < target)
        begin
            wait_drained();
            pick_random_setup();
            repeat ($urandom_range(2, 6)) run_search();
        end
    endtask

    initial
    begin
        int hold;
        @(posedge clk);
        forever
        begin
            hold = out_hurry ? 0 : $urandom_range(0, 12);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    always @(posedge clk)
    begin
        hit_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_hits.size() == 0)
            begin
                note_failure($sformatf("result with nothing expected: found=%0d off=%h",
                                       found, match_offset));
            end
            else
            begin
                want = expected_hits.pop_front();
                if (found !== want.found || match_offset !== want.offs
                    || line_start_offset !== want.line_start || line_number !== want.line
                    || horizontal_shift !== want.shift)
                begin
                    note_failure($sformatf(
                        "expected found=%0d off=%h line_start=%h line=%h shift=%h",
                        want.found, want.offs, want.line_start, want.line, want.shift));
                    if (errors <= 10)
                        $display("    got found=%0d off=%h line_start=%h line=%h shift=%h",
                                 found, match_offset, line_start_offset, line_number,
                                 horizontal_shift);
                end
            end
        end
    end

    // Ends the run when neither channel has moved a beat for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_exact_case();
        test_folded_case();
        test_full_window();
        test_random_searches();
        wait_drained();
        if (errors == 0 && expected_hits.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
